// ----- hdl/swa_pkg.sv -----
// shared constants and types of the sliding window average unit
// no dependencies; used by swa_ring, swa_div and the top level
package swa_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int SAMPLE_W   = 32;
  localparam int WIN_W      = 7;
  localparam int SUM_W      = SAMPLE_W + ADDR_W;
  localparam int CNT_W      = $clog2(SUM_W);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);

  typedef struct packed {
    logic busy;
    logic done;
  } swa_div_stat_t;

endpackage

// ----- hdl/swa_ring.sv -----
// history ring of past samples: one write port, one registered read port
// depends on swa_pkg
module swa_ring
  import swa_pkg::*;
(
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem_r [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;

  // read returns the old contents when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/swa_div.sv -----
// bit-serial signed divider of the running sum by the window length
// one quotient bit per cycle, truncates toward zero; depends on swa_pkg
module swa_div
  import swa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [WIN_W-1:0]    divisor,
  output logic [SAMPLE_W-1:0] quotient,
  output swa_div_stat_t       stat
);

  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [WIN_W-1:0]  rem_r, rem_nxt;
  logic [WIN_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [WIN_W:0]    trial;
  logic [WIN_W:0]    diff;
  logic              qbit;
  logic [SUM_W-1:0]  mag;

  assign mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

  always_comb begin
    trial   = {rem_r, dvd_r[SUM_W-1]};
    diff    = trial - {1'b0, div_r};
    qbit    = (trial >= {1'b0, div_r});
    rem_nxt = qbit ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    dvd_nxt = {dvd_r[SUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= mag;
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  // the mean always fits the sample width, so only the low bits are signed back
  assign quotient  = neg_r ? (~dvd_r[SAMPLE_W-1:0] + SAMPLE_W'(1)) : dvd_r[SAMPLE_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- hdl/sliding_window_average_unit.sv -----
// sliding window average unit: mean of the preceding window_length samples
// each input beat starts the bit-serial divider on the running sum of the preceding
// window; its quotient is loaded into the output register before the next beat is taken
// in_tready is low while an item is in work or its result cannot be loaded
// reset (synchronous, rst_n low): window empty, window_length = 10, no result held
module sliding_window_average_unit
  import swa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [WIN_W-1:0]    cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [31:0] sample
  input  logic                in_tlast,   // end_of_series
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,  // [31:0] average
  output logic                out_tuser,  // average_valid
  output logic                out_tlast   // last_result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [WIN_W-1:0]    win_r;
  logic [WIN_W-1:0]    fill_r;
  logic [ADDR_W-1:0]   wp_r;
  logic [SUM_W-1:0]    sum_r;
  logic                valid_r;
  logic                last_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_user_r;
  logic                out_last_r;

  logic [WIN_W-1:0]    win_eff;
  logic                win_full;
  logic [ADDR_W-1:0]   old_addr;
  logic                accept;
  logic                load_out;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] quotient;
  swa_div_stat_t       div_stat;

  always_comb begin
    win_eff = win_r;
    if (win_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_r > WIN_MAX) begin
      win_eff = WIN_MAX;
    end
  end

  assign win_full = (fill_r >= win_eff);
  // oldest sample of the window; a full-size window wraps onto the write slot
  assign old_addr = wp_r - win_eff[ADDR_W-1:0];
  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign load_out = (state_r == ST_WAIT) && div_stat.done && !div_stat.busy &&
                    (!out_valid_r || out_tready);

  swa_ring u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wp_r),
    .wr_data (in_tdata),
    .rd_en   (accept),
    .rd_addr (old_addr),
    .rd_data (old_sample)
  );

  swa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (sum_r),
    .divisor  (win_eff),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= WIN_RESET;
      fill_r      <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      valid_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        win_r  <= cfg_wr_data;
        fill_r <= '0;
        wp_r   <= '0;
        sum_r  <= '0;
      end else if (accept) begin
        // divider takes the old sum on this edge, the new sample goes in now
        valid_r <= win_full;
        last_r  <= in_tlast;
        sum_r   <= sum_r + {{ADDR_W{in_tdata[SAMPLE_W-1]}}, in_tdata};
        wp_r    <= wp_r + ADDR_W'(1);
        if (!win_full) begin
          fill_r <= fill_r + WIN_W'(1);
        end
      end else if (state_r == ST_UPD) begin
        if (last_r) begin
          fill_r <= '0;
          wp_r   <= '0;
          sum_r  <= '0;
        end else if (valid_r) begin
          sum_r <= sum_r - {{ADDR_W{old_sample[SAMPLE_W-1]}}, old_sample};
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= valid_r ? quotient : '0;
      out_user_r <= valid_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
